### rtl/core/id_interning_table_defines.svh
// assertion helpers used by the table rtl
`ifndef ID_INTERNING_TABLE_DEFINES_SVH
`define ID_INTERNING_TABLE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IDT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("interning table check failed");

// next-cycle implication, checked out of reset
`define IDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("interning table check failed");

`endif

### rtl/core/idt_pkg.sv
package idt_pkg;

  localparam int ID_W  = 32;
  localparam int IDX_W = 16;

  // request modes
  localparam logic MODE_FIND = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_OVERFLOW      = 2'd1,
    ST_OUT_OF_BOUNDS = 2'd2
  } status_t;

  // request token walking down the cell row
  typedef struct packed {
    logic             mode;
    logic [ID_W-1:0]  key;
    logic [IDX_W-1:0] index;
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [ID_W-1:0]  value;
    logic             added;
  } tok_t;

endpackage

### rtl/core/idt_if.sv
interface idt_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [idt_pkg::ID_W-1:0]  id_value;
  logic [idt_pkg::IDX_W-1:0] entry_index;

  modport source (output valid, mode, id_value, entry_index, input ready);
  modport sink (input valid, mode, id_value, entry_index, output ready);
endinterface

interface idt_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [idt_pkg::IDX_W-1:0] index_result;
  logic [idt_pkg::ID_W-1:0]  id_result;
  logic                      was_added;

  modport source (output valid, status, index_result, id_result, was_added, input ready);
  modport sink (input valid, status, index_result, id_result, was_added, output ready);
endinterface

### rtl/core/id_interning_table.sv
// Interns 32-bit ids into dense 16-bit indices. A find request (mode 0) returns the
// lowest index holding id_value, or appends it at the next free index (was_added set),
// or reports overflow when all TABLE_DEPTH slots are used. A read request (mode 1)
// returns the id stored at entry_index, or out of bounds when the index is not in use.
// Each slot lives in a cell of a row; a request walks the row one cell per cycle, and
// its result is registered at the end of the row and shown in S_REPLY. The next
// request is taken the cycle after the result is accepted. The table holds no request
// while one is in flight.
`include "id_interning_table_defines.svh"

module id_interning_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  idt_in_if.sink     in_req,
  idt_out_if.source  out_rsp
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_REPLY  = 3'b100
  } state_t;

  state_t                      state_r;
  state_t                      state_nxt;
  logic [CNT_W-1:0]            count_r;
  logic [1:0]                  status_r;
  logic [idt_pkg::IDX_W-1:0]   index_r;
  logic [idt_pkg::ID_W-1:0]    value_r;
  logic                        added_r;

  logic                        chain_vld [TABLE_DEPTH+1];
  idt_pkg::tok_t               chain_tok [TABLE_DEPTH+1];
  idt_pkg::tok_t               last_tok;
  logic                        last_vld;
  logic                        accept;
  logic                        deliver;

  assign accept  = in_req.valid && in_req.ready;
  assign deliver = out_rsp.valid && out_rsp.ready;

  assign in_req.ready = state_r == S_IDLE;

  always_comb begin
    chain_vld[0]       = accept;
    chain_tok[0].mode  = in_req.mode;
    chain_tok[0].key   = in_req.id_value;
    chain_tok[0].index = in_req.entry_index;
    chain_tok[0].hit   = 1'b0;
    chain_tok[0].idx   = '0;
    chain_tok[0].value = '0;
    chain_tok[0].added = 1'b0;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    idt_cell #(
      .CELL_IDX (g),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .used_count  (count_r),
      .tok_vld_in  (chain_vld[g]),
      .tok_in      (chain_tok[g]),
      .tok_vld_out (chain_vld[g+1]),
      .tok_out     (chain_tok[g+1])
    );
  end

  assign last_vld = chain_vld[TABLE_DEPTH];
  assign last_tok = chain_tok[TABLE_DEPTH];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept) state_nxt = S_SEARCH;
      S_SEARCH: if (last_vld) state_nxt = S_REPLY;
      S_REPLY:  if (deliver) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (last_vld && last_tok.added) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  // result formatting at the end of the row
  always_ff @(posedge clk) begin
    if (last_vld) begin
      if (last_tok.mode == idt_pkg::MODE_FIND) begin
        status_r <= last_tok.hit ? idt_pkg::ST_OK : idt_pkg::ST_OVERFLOW;
        index_r  <= last_tok.hit ? last_tok.idx : '0;
        value_r  <= '0;
        added_r  <= last_tok.added;
      end else begin
        status_r <= last_tok.hit ? idt_pkg::ST_OK : idt_pkg::ST_OUT_OF_BOUNDS;
        index_r  <= '0;
        value_r  <= last_tok.hit ? last_tok.value : '0;
        added_r  <= 1'b0;
      end
    end
  end

  assign out_rsp.valid        = state_r == S_REPLY;
  assign out_rsp.status       = status_r;
  assign out_rsp.index_result = index_r;
  assign out_rsp.id_result    = value_r;
  assign out_rsp.was_added    = added_r;

  `IDT_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= FULL_CNT)
  `IDT_ASSERT_NOW(a_exit_in_search, clk, rst_n, last_vld, state_r == S_SEARCH)
  `IDT_ASSERT_NOW(a_no_append_when_full, clk, rst_n, last_vld && count_r == FULL_CNT,
                  !last_tok.added)
  `IDT_ASSERT_NEXT(a_count_stable, clk, rst_n, !(last_vld && last_tok.added),
                   $stable(count_r))

endmodule

### rtl/core/idt_cell.sv
module idt_cell #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [CNT_W-1:0]     used_count,
  input  logic                 tok_vld_in,
  input  idt_pkg::tok_t        tok_in,
  output logic                 tok_vld_out,
  output idt_pkg::tok_t        tok_out
);

  localparam logic [CNT_W-1:0]          MY_CNT = CNT_W'(CELL_IDX);
  localparam logic [idt_pkg::IDX_W-1:0] MY_IDX = idt_pkg::IDX_W'(CELL_IDX);

  logic [idt_pkg::ID_W-1:0] entry_r;
  logic                     vld_r;
  idt_pkg::tok_t            tok_r;
  idt_pkg::tok_t            tok_nxt;
  logic                     below;
  logic                     at_tail;
  logic                     append;

  assign below   = MY_CNT < used_count;
  assign at_tail = MY_CNT == used_count;

  always_comb begin
    tok_nxt = tok_in;
    append  = 1'b0;
    if (tok_in.mode == idt_pkg::MODE_FIND) begin
      if (!tok_in.hit && below && entry_r == tok_in.key) begin
        tok_nxt.hit = 1'b1;
        tok_nxt.idx = MY_IDX;
      end else if (!tok_in.hit && at_tail) begin
        // first free slot: take the new id
        append        = tok_vld_in;
        tok_nxt.hit   = 1'b1;
        tok_nxt.idx   = MY_IDX;
        tok_nxt.added = 1'b1;
      end
    end else begin
      if (below && tok_in.index == MY_IDX) begin
        tok_nxt.hit   = 1'b1;
        tok_nxt.value = entry_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (append) begin
      entry_r <= tok_in.key;
    end
    tok_r <= tok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= tok_vld_in;
    end
  end

  assign tok_vld_out = vld_r;
  assign tok_out     = tok_r;

endmodule
